// ===== sv/wsfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// shared widths, phase codes and byte kind codes for the frame deframer
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned OPC_W   = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned KEY_N   = 4;

  // tdata: out_data, then kept_total
  localparam int unsigned TDATA_W = BYTE_W + LEN_W;
  // tuser: byte_kind, then frame_opcode, padded to a byte
  localparam int unsigned TUSER_W = 8;

  localparam logic [LEN_W-1:0] KEEP_LIMIT_RST = 16'd127;

  // header walk
  localparam logic [PHASE_W-1:0] PH_B0     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_B1     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_EXT_HI = 4'd2;
  localparam logic [PHASE_W-1:0] PH_EXT_LO = 4'd3;
  localparam logic [PHASE_W-1:0] PH_KEY0   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_KEY1   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_KEY2   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_KEY3   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_DATA   = 4'd8;

  localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEEP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

  localparam logic [BYTE_W-1:0] MASK_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] LEN7_MASK = 8'h7F;
  localparam logic [LEN_W-1:0]  LEN_EXT16 = 16'd126;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage : wsfd_pkg
`default_nettype wire

// ===== sv/websocket_frame_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// walks websocket frame headers one byte a word and unmasks the payload
// ----------------------------------------------------------------------------
// usage:
//   - s_axis carries the received byte stream, one byte per word
//   - m_axis returns exactly one word per input word: the raw header byte or
//     the unmasked payload byte, its kind, the current opcode, the running
//     kept count, and tlast on the word that completes a frame
//   - cfg_wr_en / cfg_wr_data load keep_limit; write it only while idle
//   - the result of a byte accepted on s_axis is offered on m_axis from the
//     next cycle on
//   - throughput is one byte per cycle while m_axis_tready holds; the header
//     walk and the unmask are a single pass of logic in front of the result register
//   - a new byte is accepted while the result register is empty or being
//     drained in the same cycle, so a stalled receiver holds the result and
//     back-pressures s_axis without losing or repeating a word
//   - reset (rst, synchronous) empties the result register, returns to the
//     first header byte, clears the frame state and sets keep_limit to 127
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration: keep_limit
  input  wire logic               cfg_wr_en,
  input  wire logic [LEN_W-1:0]   cfg_wr_data,
  // received stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  // parsed stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] out_data, [23:8] kept_total
  output logic                    m_axis_tlast,   // frame_end
  output logic [TUSER_W-1:0]      m_axis_tuser    // [1:0] byte_kind, [5:2] frame_opcode
);

  // configuration register
  logic [LEN_W-1:0]   keep_limit;

  // frame state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [OPC_W-1:0]   opcode_held, opcode_held_next;
  logic               mask_on, mask_on_next;
  logic [LEN_W-1:0]   frame_len, frame_len_next;
  byte_t              mask_key [KEY_N];
  logic [LEN_W-1:0]   payload_index, payload_index_next;
  logic [LEN_W-1:0]   kept_count, kept_count_next;

  // key update controls
  logic               key_clear;
  logic               key_wr;
  logic [1:0]         key_sel;

  // result word before the output register
  byte_t              res_data;
  logic [KIND_W-1:0]  res_kind;
  logic               res_end;

  logic               in_accept;
  logic [LEN_W-1:0]   len7;
  logic [LEN_W-1:0]   index_inc;

  // result register drains or is empty: take a new byte
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign len7      = {{(LEN_W-BYTE_W){1'b0}}, s_axis_tdata & LEN7_MASK};
  assign index_inc = payload_index + 16'd1;

  // header walk and payload unmask, one byte per pass
  always_comb begin
    phase_next         = phase;
    opcode_held_next   = opcode_held;
    mask_on_next       = mask_on;
    frame_len_next     = frame_len;
    payload_index_next = payload_index;
    kept_count_next    = kept_count;
    key_clear          = 1'b0;
    key_wr             = 1'b0;
    key_sel            = phase[1:0];
    res_data           = s_axis_tdata;
    res_kind           = KIND_HDR;
    res_end            = 1'b0;

    unique case (phase)
      PH_B1: begin
        mask_on_next   = (s_axis_tdata & MASK_BIT) != '0;
        frame_len_next = len7;
        if (len7 == LEN_EXT16) begin
          phase_next = PH_EXT_HI;
        end else if ((s_axis_tdata & MASK_BIT) != '0) begin
          phase_next = PH_KEY0;
        end else if (len7 == '0) begin
          phase_next = PH_B0;
          res_end    = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_EXT_HI: begin
        frame_len_next = {s_axis_tdata, {(LEN_W-BYTE_W){1'b0}}};
        phase_next     = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        frame_len_next = frame_len | {{(LEN_W-BYTE_W){1'b0}}, s_axis_tdata};
        if (mask_on) begin
          phase_next = PH_KEY0;
        end else if (frame_len_next == '0) begin
          phase_next = PH_B0;
          res_end    = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        key_wr     = 1'b1;
        phase_next = phase + 4'd1;
      end
      PH_KEY3: begin
        key_wr = 1'b1;
        if (frame_len == '0) begin
          phase_next = PH_B0;
          res_end    = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (mask_on) begin
          res_data = s_axis_tdata ^ mask_key[payload_index[1:0]];
        end
        if (payload_index < keep_limit) begin
          res_kind        = KIND_KEEP;
          kept_count_next = kept_count + 16'd1;
        end else begin
          res_kind = KIND_DROP;
        end
        payload_index_next = index_inc;
        if (index_inc >= frame_len) begin
          res_end    = 1'b1;
          phase_next = PH_B0;
        end
      end
      default: begin
        // first header byte, also recovers from unused codes
        opcode_held_next   = s_axis_tdata[OPC_W-1:0];
        mask_on_next       = 1'b0;
        frame_len_next     = '0;
        payload_index_next = '0;
        kept_count_next    = '0;
        key_clear          = 1'b1;
        phase_next         = PH_B1;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= KEEP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      keep_limit <= cfg_wr_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_B0;
      opcode_held   <= '0;
      mask_on       <= 1'b0;
      frame_len     <= '0;
      payload_index <= '0;
      kept_count    <= '0;
      for (int i = 0; i < KEY_N; i++) begin
        mask_key[i] <= '0;
      end
    end else if (in_accept) begin
      phase         <= phase_next;
      opcode_held   <= opcode_held_next;
      mask_on       <= mask_on_next;
      frame_len     <= frame_len_next;
      payload_index <= payload_index_next;
      kept_count    <= kept_count_next;
      if (key_clear) begin
        for (int i = 0; i < KEY_N; i++) begin
          mask_key[i] <= '0;
        end
      end else if (key_wr) begin
        mask_key[key_sel] <= s_axis_tdata;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_axis_tdata <= {kept_count_next, res_data};
      m_axis_tlast <= res_end;
      m_axis_tuser <= {2'b00, opcode_held_next, res_kind};
    end
  end

endmodule : websocket_frame_deframer_unit
`default_nettype wire
